// ===== rtl/core/json_path_tokenizer_core_defines.svh =====
// assertion macros used by the tokenizer checker
`ifndef JSON_PATH_TOKENIZER_CORE_DEFINES_SVH
`define JSON_PATH_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define JPT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define JPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/jpt_pkg.sv =====
// types and constants of the json path tokenizer
`default_nettype none

package jpt_pkg;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_INDEX = 2'd1,
    KIND_WILD  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [8:0] {
    M_START   = 9'b000000001,
    M_IDLE    = 9'b000000010,
    M_KEY     = 9'b000000100,
    M_BRACKET = 9'b000001000,
    M_WILD    = 9'b000010000,
    M_NUM     = 9'b000100000,
    M_QUOTED  = 9'b001000000,
    M_AFTERQ  = 9'b010000000,
    M_ERR     = 9'b100000000
  } mode_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int OFF_W = 12;
  localparam int LEN_W = 13;
  localparam int IDX_W = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // everything one word produces: an optional component, an optional done
  typedef struct packed {
    logic               has_comp;
    kind_t              comp_kind;
    logic [OFF_W-1:0]   key_offset;
    logic [LEN_W-1:0]   key_length;
    logic [IDX_W-1:0]   index_value;
    logic               has_done;
    logic               parse_failed;
  } pkt_t;

  typedef struct packed {
    kind_t              kind;
    logic [OFF_W-1:0]   key_offset;
    logic [LEN_W-1:0]   key_length;
    logic [IDX_W-1:0]   index_value;
    logic               parse_failed;
    logic               last_of_item;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/jpt_in_if.sv =====
// character channel of the tokenizer
`default_nettype none

interface jpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/jpt_out_if.sv =====
// result channel of the tokenizer
`default_nettype none

interface jpt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [11:0]        key_offset;
  logic [12:0]        key_length;
  logic signed [63:0] index_value;
  logic               parse_failed;
  logic               last_of_item;

  modport source (output valid, output kind, output key_offset, output key_length,
                  output index_value, output parse_failed, output last_of_item,
                  input ready);
  modport sink   (input valid, input kind, input key_offset, input key_length,
                  input index_value, input parse_failed, input last_of_item,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/jpt_queue.sv =====
// short packet queue between the classifier and the result sequencer
`default_nettype none

module jpt_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire jpt_pkg::pkt_t push_pkt,
  input  wire logic          pop,
  output jpt_pkg::pkt_t      head_pkt,
  output jpt_pkg::q_stat_t   stat
);
  import jpt_pkg::*;

  pkt_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  assign head_pkt   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

// ===== rtl/core/jpt_front.sv =====
// path state machine: classifies each character and builds result packets
`default_nettype none

module jpt_front #(
  parameter int MAX_PATH_LEN = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  char_byte,
  input  wire logic        is_last,
  output logic             push,
  output jpt_pkg::pkt_t    push_pkt
);
  import jpt_pkg::*;

  localparam int POS_W  = $clog2(MAX_PATH_LEN + 1);
  localparam int CALC_W = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PATH_LEN);

  mode_t              mode_r, mode_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   tstart_r, tstart_nxt;
  logic [IDX_W-1:0]   acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic               seen_r, seen_nxt;
  logic               dquote_r, dquote_nxt;
  logic               esc_r, esc_nxt;
  logic               err_r, err_nxt;

  logic               is_digit;
  logic               do_idle;
  logic [7:0]         close_q;
  logic [IDX_W-1:0]   acc_x10;
  pkt_t               pkt;

  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign close_q  = dquote_r ? CH_DQUOTE : CH_SQUOTE;
  // times ten as two shifted adds, plus the digit
  assign acc_x10  = {acc_r[IDX_W-4:0], 3'b000} + {acc_r[IDX_W-2:0], 1'b0}
                  + {{(IDX_W-4){1'b0}}, char_byte[3:0]};

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    seen_nxt   = seen_r;
    dquote_nxt = dquote_r;
    esc_nxt    = esc_r;
    err_nxt    = err_r;
    do_idle    = 1'b0;
    pkt        = '0;
    pkt.comp_kind = KIND_KEY;

    if (mode_r != M_ERR && pos_r >= MAX_POS) begin
      err_nxt  = 1'b1;
      mode_nxt = M_ERR;
    end else begin
      case (mode_r)
        M_START: begin
          if (char_byte == CH_DOLLAR) mode_nxt = M_IDLE;
          else do_idle = 1'b1;
        end
        M_IDLE: do_idle = 1'b1;
        M_KEY: begin
          if (char_byte == CH_DOT || char_byte == CH_LBRACK) begin
            pkt.has_comp   = 1'b1;
            pkt.comp_kind  = KIND_KEY;
            pkt.key_offset = OFF_W'(tstart_r);
            pkt.key_length = LEN_W'(CALC_W'(pos_r) - CALC_W'(tstart_r));
            mode_nxt = (char_byte == CH_LBRACK) ? M_BRACKET : M_IDLE;
          end
        end
        M_BRACKET: begin
          acc_nxt  = '0;
          neg_nxt  = 1'b0;
          seen_nxt = 1'b0;
          esc_nxt  = 1'b0;
          if (char_byte == CH_STAR) begin
            mode_nxt = M_WILD;
          end else if (char_byte == CH_SQUOTE || char_byte == CH_DQUOTE) begin
            dquote_nxt = (char_byte == CH_DQUOTE);
            tstart_nxt = pos_r + 1'b1;
            mode_nxt   = M_QUOTED;
          end else if (char_byte == CH_MINUS) begin
            neg_nxt  = 1'b1;
            mode_nxt = M_NUM;
          end else if (is_digit) begin
            acc_nxt  = {{(IDX_W-4){1'b0}}, char_byte[3:0]};
            seen_nxt = 1'b1;
            mode_nxt = M_NUM;
          end else begin
            err_nxt  = 1'b1;
            mode_nxt = M_ERR;
          end
        end
        M_WILD: begin
          if (char_byte == CH_RBRACK) begin
            pkt.has_comp  = 1'b1;
            pkt.comp_kind = KIND_WILD;
            mode_nxt      = M_IDLE;
          end else begin
            err_nxt  = 1'b1;
            mode_nxt = M_ERR;
          end
        end
        M_NUM: begin
          if (is_digit) begin
            acc_nxt  = acc_x10;
            seen_nxt = 1'b1;
          end else if (char_byte == CH_RBRACK && seen_r) begin
            pkt.has_comp    = 1'b1;
            pkt.comp_kind   = KIND_INDEX;
            pkt.index_value = neg_r ? ('0 - acc_r) : acc_r;
            mode_nxt        = M_IDLE;
          end else begin
            err_nxt  = 1'b1;
            mode_nxt = M_ERR;
          end
        end
        M_QUOTED: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (char_byte == close_q) begin
            pkt.has_comp   = 1'b1;
            pkt.comp_kind  = KIND_KEY;
            pkt.key_offset = OFF_W'(tstart_r);
            pkt.key_length = LEN_W'(CALC_W'(pos_r) - CALC_W'(tstart_r));
            mode_nxt       = M_AFTERQ;
          end else if (char_byte == CH_BSLASH && !is_last) begin
            esc_nxt = 1'b1;
          end
        end
        M_AFTERQ: begin
          if (char_byte == CH_RBRACK) mode_nxt = M_IDLE;
          else do_idle = 1'b1;
        end
        M_ERR: mode_nxt = M_ERR;
        default: mode_nxt = M_ERR;
      endcase
    end

    // character seen between components
    if (do_idle) begin
      if (char_byte == CH_DOT) begin
        mode_nxt = M_IDLE;
      end else if (char_byte == CH_LBRACK) begin
        mode_nxt = M_BRACKET;
      end else begin
        tstart_nxt = pos_r;
        mode_nxt   = M_KEY;
      end
    end

    if (pos_r < MAX_POS) pos_nxt = pos_r + 1'b1;

    // end of path: close any open key, flag an open bracket, then start over
    if (is_last) begin
      if (mode_nxt == M_KEY || mode_nxt == M_QUOTED) begin
        pkt.has_comp   = 1'b1;
        pkt.comp_kind  = KIND_KEY;
        pkt.key_offset = OFF_W'(tstart_nxt);
        pkt.key_length = LEN_W'(CALC_W'(pos_r) + 1'b1 - CALC_W'(tstart_nxt));
      end else if (mode_nxt == M_BRACKET || mode_nxt == M_WILD || mode_nxt == M_NUM) begin
        err_nxt = 1'b1;
      end
      pkt.has_done     = 1'b1;
      pkt.parse_failed = err_nxt;
      mode_nxt   = M_START;
      pos_nxt    = '0;
      tstart_nxt = '0;
      acc_nxt    = '0;
      neg_nxt    = 1'b0;
      seen_nxt   = 1'b0;
      dquote_nxt = 1'b0;
      esc_nxt    = 1'b0;
      err_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_START;
      pos_r    <= '0;
      tstart_r <= '0;
      acc_r    <= '0;
      neg_r    <= 1'b0;
      seen_r   <= 1'b0;
      dquote_r <= 1'b0;
      esc_r    <= 1'b0;
      err_r    <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      seen_r   <= seen_nxt;
      dquote_r <= dquote_nxt;
      esc_r    <= esc_nxt;
      err_r    <= err_nxt;
    end
  end

  assign push     = accept && (pkt.has_comp || pkt.has_done);
  assign push_pkt = pkt;

endmodule

`default_nettype wire

// ===== rtl/core/jpt_back.sv =====
// result sequencer: splits packets into words behind an output register
`default_nettype none

module jpt_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire jpt_pkg::pkt_t    head_pkt,
  input  wire jpt_pkg::q_stat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output jpt_pkg::result_t      out_res
);
  import jpt_pkg::*;

  logic    valid_r, valid_nxt;
  logic    phase_r, phase_nxt;
  result_t res_r, res_nxt;
  logic    take;
  logic    comp_phase;

  always_comb begin
    take       = !stat.empty && (!valid_r || out_ready);
    comp_phase = head_pkt.has_comp && !phase_r;
    res_nxt    = '0;
    if (comp_phase) begin
      res_nxt.kind         = head_pkt.comp_kind;
      res_nxt.key_offset   = head_pkt.key_offset;
      res_nxt.key_length   = head_pkt.key_length;
      res_nxt.index_value  = head_pkt.index_value;
      res_nxt.last_of_item = !head_pkt.has_done;
    end else begin
      res_nxt.kind         = KIND_DONE;
      res_nxt.parse_failed = head_pkt.parse_failed;
      res_nxt.last_of_item = 1'b1;
    end
    pop       = take && (!comp_phase || !head_pkt.has_done);
    phase_nxt = take ? (comp_phase && head_pkt.has_done) : phase_r;
    valid_nxt = take ? 1'b1 : (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/json_path_tokenizer_core.sv =====
// top level of the streaming json path tokenizer
//
// usage
//   in_if  : one path byte per word (char_byte), is_last marks the final byte
//   out_if : one path component per word (key, index or wildcard) and one
//            done word per path carrying parse_failed; last_of_item marks the
//            final word caused by an input byte
//   keys come out as offset and length into the path, indices as 64-bit
//   two's complement values; words before a failed done are to be dropped
// timing
//   a byte is taken every cycle while the four-entry packet queue has room
//   first result word passes through the packet queue, then the output register
//   the final byte of a path produces up to two words, drained one per cycle
//   by the result sequencer while out_if is ready, so a burst of one-byte paths
//   is held back by a full queue; ordinary paths run at one byte a cycle
// reset and stall
//   rst_n low clears the path state, the queue and the output valid flag
//   a stalled out_if holds its word; the queue then fills and in_if.ready drops
`default_nettype none

module json_path_tokenizer_core #(
  parameter int MAX_PATH_LEN = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  jpt_in_if.sink      in_if,
  jpt_out_if.source   out_if
);
  import jpt_pkg::*;

  // front/back link
  logic     push;
  pkt_t     push_pkt;
  pkt_t     head_pkt;
  logic     pop;
  q_stat_t  q_stat;
  result_t  out_res;
  logic     in_accept;

  // input word taken whenever the queue can hold its packet
  assign in_if.ready = !q_stat.full;
  assign in_accept   = in_if.valid && !q_stat.full;

  jpt_front #(
    .MAX_PATH_LEN (MAX_PATH_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .char_byte (in_if.char_byte),
    .is_last   (in_if.is_last),
    .push      (push),
    .push_pkt  (push_pkt)
  );

  // decouples the classifier from output back-pressure
  jpt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .head_pkt (head_pkt),
    .stat     (q_stat)
  );

  jpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_pkt  (head_pkt),
    .stat      (q_stat),
    .pop       (pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (out_res)
  );

  // result word onto the channel
  assign out_if.kind         = out_res.kind;
  assign out_if.key_offset   = out_res.key_offset;
  assign out_if.key_length   = out_res.key_length;
  assign out_if.index_value  = $signed(out_res.index_value);
  assign out_if.parse_failed = out_res.parse_failed;
  assign out_if.last_of_item = out_res.last_of_item;

endmodule

`default_nettype wire

// ===== rtl/core/jpt_checker.sv =====
// port-level checks on the tokenizer result channel, bound to the top level
`default_nettype none
`include "json_path_tokenizer_core_defines.svh"

module jpt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         kind,
  input wire logic [11:0]        key_offset,
  input wire logic [12:0]        key_length,
  input wire logic signed [63:0] index_value,
  input wire logic               parse_failed,
  input wire logic               last_of_item
);
  import jpt_pkg::*;

  // stalled word keeps its kind and payload
  `JPT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(key_offset) && $stable(key_length) && $stable(index_value) && $stable(parse_failed), "stalled result word changed")

  // the done word always closes its input byte
  `JPT_ASSERT_IMPLY(a_done_last, out_valid && kind == KIND_DONE, last_of_item, "done word without last_of_item")

  // key fields only on keys, index only on indices, failure only on done
  `JPT_ASSERT_IMPLY(a_key_fields, out_valid && kind != KIND_KEY, key_offset == 12'd0 && key_length == 13'd0, "key fields set on non-key word")
  `JPT_ASSERT_IMPLY(a_idx_field, out_valid && kind != KIND_INDEX, index_value == 64'sd0, "index set on non-index word")
  `JPT_ASSERT_IMPLY(a_fail_done, out_valid && kind != KIND_DONE, !parse_failed, "failure flag on component word")

endmodule

bind json_path_tokenizer_core jpt_checker u_jpt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .kind         (out_if.kind),
  .key_offset   (out_if.key_offset),
  .key_length   (out_if.key_length),
  .index_value  (out_if.index_value),
  .parse_failed (out_if.parse_failed),
  .last_of_item (out_if.last_of_item)
);

`default_nettype wire

// ===== test/tb_json_path_tokenizer_core.sv =====
// testbench of the json path tokenizer: random and directed paths checked word by word
`timescale 1ns / 100ps

module tb_json_path_tokenizer_core;
  import jpt_pkg::*;

  localparam int MAX_LEN       = 4096;
  localparam int RANDOM_BYTES  = 1150;
  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 20;

  // one path byte waiting to be offered, optionally held back until all words are in
  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         wait_drain;
  } byte_item_t;

  logic clk;
  logic rst_n;

  jpt_in_if  in_if();
  jpt_out_if out_if();

  json_path_tokenizer_core #(
    .MAX_PATH_LEN(MAX_LEN)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  // bytes still to be offered, and words still to arrive
  byte_item_t  char_stream[$];
  logic [7:0]  path_buf[$];
  result_t     pending_words[$];
  result_t     step_words[$];

  int unsigned total_bytes;
  int unsigned accepted_bytes;
  int unsigned words_seen;
  int unsigned mismatches;
  int unsigned idle_phase;
  int unsigned phase_edge_a;
  int unsigned phase_edge_b;

  // tokenizer state as the checker sees it
  mode_t       tk_mode;
  int unsigned tk_pos;
  int unsigned tk_start;
  logic [63:0] tk_acc;
  bit          tk_neg;
  bit          tk_digit;
  bit          tk_dquote;
  bit          tk_escape;
  bit          tk_failed;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ------------------------------------------------------------------
  // tokenizer prediction
  // ------------------------------------------------------------------

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_path_state();
    tk_mode   = M_START;
    tk_pos    = 0;
    tk_start  = 0;
    tk_acc    = '0;
    tk_neg    = 1'b0;
    tk_digit  = 1'b0;
    tk_dquote = 1'b0;
    tk_escape = 1'b0;
    tk_failed = 1'b0;
  endtask

  // offset and length are cut to their port widths here, as the hardware does
  task automatic add_word(kind_t k, int unsigned off, int unsigned len,
                          logic [63:0] idx, bit failed);
    result_t w;
    w.kind         = k;
    w.key_offset   = off[OFF_W-1:0];
    w.key_length   = len[LEN_W-1:0];
    w.index_value  = idx;
    w.parse_failed = failed;
    w.last_of_item = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic flag_error();
    tk_failed = 1'b1;
    tk_mode   = M_ERR;
  endtask

  // a byte between components: dot skipped, bracket opened, anything else starts a key
  task automatic begin_component(logic [7:0] c, int unsigned p);
    if (c == CH_DOT) begin
      tk_mode = M_IDLE;
    end else if (c == CH_LBRACK) begin
      tk_mode = M_BRACKET;
    end else begin
      tk_start = p;
      tk_mode  = M_KEY;
    end
  endtask

  // first byte after '[' picks wildcard, quoted key or index
  task automatic open_bracket(logic [7:0] c, int unsigned p);
    tk_acc    = '0;
    tk_neg    = 1'b0;
    tk_digit  = 1'b0;
    tk_escape = 1'b0;
    if (c == CH_STAR) begin
      tk_mode = M_WILD;
    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      tk_dquote = (c == CH_DQUOTE);
      tk_start  = p + 1;
      tk_mode   = M_QUOTED;
    end else if (c == CH_MINUS) begin
      tk_neg  = 1'b1;
      tk_mode = M_NUM;
    end else if (is_digit(c)) begin
      tk_acc   = 64'(c - CH_ZERO);
      tk_digit = 1'b1;
      tk_mode  = M_NUM;
    end else begin
      flag_error();
    end
  endtask

  // one accepted byte in, zero to two expected words out
  task automatic tokenize_byte(logic [7:0] c, logic last);
    int unsigned p;
    p = tk_pos;
    step_words.delete();
    if (tk_mode != M_ERR && p >= MAX_LEN) begin
      // overlong path
      flag_error();
    end else begin
      case (tk_mode)
        M_START: begin
          if (c == CH_DOLLAR) tk_mode = M_IDLE;
          else begin_component(c, p);
        end
        M_IDLE: begin
          begin_component(c, p);
        end
        M_KEY: begin
          if (c == CH_DOT || c == CH_LBRACK) begin
            add_word(KIND_KEY, tk_start, p - tk_start, '0, 1'b0);
            tk_mode = (c == CH_LBRACK) ? M_BRACKET : M_IDLE;
          end
        end
        M_BRACKET: begin
          open_bracket(c, p);
        end
        M_WILD: begin
          if (c == CH_RBRACK) begin
            add_word(KIND_WILD, 0, 0, '0, 1'b0);
            tk_mode = M_IDLE;
          end else begin
            flag_error();
          end
        end
        M_NUM: begin
          if (is_digit(c)) begin
            // wraps modulo 2^64 by the width alone
            tk_acc   = tk_acc * 64'd10 + 64'(c - CH_ZERO);
            tk_digit = 1'b1;
          end else if (c == CH_RBRACK && tk_digit) begin
            add_word(KIND_INDEX, 0, 0, tk_neg ? 64'd0 - tk_acc : tk_acc, 1'b0);
            tk_mode = M_IDLE;
          end else begin
            flag_error();
          end
        end
        M_QUOTED: begin
          if (tk_escape) begin
            tk_escape = 1'b0;
          end else if (c == (tk_dquote ? CH_DQUOTE : CH_SQUOTE)) begin
            add_word(KIND_KEY, tk_start, p - tk_start, '0, 1'b0);
            tk_mode = M_AFTERQ;
          end else if (c == CH_BSLASH && !last) begin
            // a trailing backslash stays an ordinary key byte
            tk_escape = 1'b1;
          end
        end
        M_AFTERQ: begin
          if (c == CH_RBRACK) tk_mode = M_IDLE;
          else begin_component(c, p);
        end
        default: begin
          tk_mode = M_ERR;
        end
      endcase
    end

    if (tk_pos < MAX_LEN) tk_pos++;

    if (last) begin
      // close any open key; an open bracket is an error
      if (tk_mode == M_KEY || tk_mode == M_QUOTED)
        add_word(KIND_KEY, tk_start, p + 1 - tk_start, '0, 1'b0);
      else if (tk_mode == M_BRACKET || tk_mode == M_WILD || tk_mode == M_NUM)
        flag_error();
      add_word(KIND_DONE, 0, 0, '0, tk_failed);
      clear_path_state();
    end

    if (step_words.size() != 0) step_words[step_words.size() - 1].last_of_item = 1'b1;
    foreach (step_words[i]) pending_words.push_back(step_words[i]);
  endtask

  // ------------------------------------------------------------------
  // path building
  // ------------------------------------------------------------------

  function automatic logic [7:0] bare_key_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_DOT || c == CH_LBRACK);
    return c;
  endfunction

  // mostly the bytes the tokenizer reacts to, now and then any byte
  function automatic logic [7:0] noise_char();
    case ($urandom_range(11))
      0: return CH_DOLLAR;
      1: return CH_DOT;
      2: return CH_LBRACK;
      3: return CH_RBRACK;
      4: return CH_STAR;
      5: return CH_MINUS;
      6: return CH_BSLASH;
      7: return CH_SQUOTE;
      8: return CH_DQUOTE;
      9: return CH_ZERO + 8'($urandom_range(9));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
  endtask

  // move the built path onto the stream, is_last on its final byte
  task automatic commit_path(bit drain);
    byte_item_t it;
    if (path_buf.size() == 0) path_buf.push_back(8'($urandom_range(255)));
    foreach (path_buf[i]) begin
      it.ch         = path_buf[i];
      it.last       = (i == path_buf.size() - 1);
      it.wait_drain = drain && (i == 0);
      char_stream.push_back(it);
    end
    path_buf.delete();
  endtask

  // mostly well-formed paths with random content, some of them broken afterwards
  task automatic build_random_path();
    int unsigned n_comp;
    int unsigned len;
    int unsigned sel;
    logic [7:0]  q;
    logic [7:0]  c;
    if ($urandom_range(2) == 0) path_buf.push_back(CH_DOLLAR);
    n_comp = $urandom_range(1, 5);
    for (int i = 0; i < n_comp; i++) begin
      // stray dots are skipped anywhere between components
      if ($urandom_range(4) == 0) path_buf.push_back(CH_DOT);
      sel = $urandom_range(99);
      if (sel < 30) begin
        if (path_buf.size() != 0) path_buf.push_back(CH_DOT);
        len = $urandom_range(1, 6);
        repeat (len) path_buf.push_back(bare_key_char());
      end else if (sel < 42) begin
        push_text("[*]");
      end else if (sel < 70) begin
        path_buf.push_back(CH_LBRACK);
        if ($urandom_range(2) == 0) path_buf.push_back(CH_MINUS);
        // long digit runs overflow the 64-bit accumulator
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 25) : $urandom_range(1, 3);
        repeat (len) path_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
        path_buf.push_back(CH_RBRACK);
      end else begin
        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        path_buf.push_back(CH_LBRACK);
        path_buf.push_back(q);
        len = $urandom_range(0, 6);
        repeat (len) begin
          c = 8'($urandom_range(255));
          if (c == q || c == CH_BSLASH || $urandom_range(7) == 0) begin
            path_buf.push_back(CH_BSLASH);
            path_buf.push_back(c);
          end else begin
            path_buf.push_back(c);
          end
        end
        // sometimes unclosed, sometimes without the closing bracket
        if ($urandom_range(9) != 0) path_buf.push_back(q);
        if ($urandom_range(4) != 0) path_buf.push_back(CH_RBRACK);
      end
    end

    if ($urandom_range(99) < 15) begin
      case ($urandom_range(2))
        0: path_buf = path_buf[0:$urandom_range(path_buf.size() - 1)];
        1: path_buf[$urandom_range(path_buf.size() - 1)] = noise_char();
        default: repeat ($urandom_range(1, 6)) path_buf.push_back(noise_char());
      endcase
    end
  endtask

  // ------------------------------------------------------------------
  // idling and checking
  // ------------------------------------------------------------------

  // phase 0: sender idles more lightly, phase 1: the reverse, phase 2: no idling
  function automatic int unsigned idle_pct(bit receiver);
    case (idle_phase)
      0: return receiver ? 53 : 35;
      1: return receiver ? 35 : 53;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("word %0d: %s got %0h want %0h", words_seen, what, got, want);
  endtask

  // byte driver: holds a word until taken, may idle between words
  always @(posedge clk) begin : char_driver
    logic       fire;
    byte_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      fire = in_if.valid && in_if.ready;
      if (fire) begin
        tokenize_byte(in_if.char_byte, in_if.is_last);
        accepted_bytes++;
        idle_phase = (accepted_bytes < phase_edge_a) ? 0 :
                     (accepted_bytes < phase_edge_b) ? 1 : 2;
      end
      if (!in_if.valid || fire) begin
        // a drain marker holds the next path back until every word is in
        if (char_stream.size() != 0 &&
            !(char_stream[0].wait_drain && pending_words.size() != 0) &&
            $urandom_range(99) >= idle_pct(1'b0)) begin
          nxt = char_stream.pop_front();
          in_if.valid     <= 1'b1;
          in_if.char_byte <= nxt.ch;
          in_if.is_last   <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // word monitor: compares each taken word with the oldest expectation
  always @(posedge clk) begin : word_monitor
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        words_seen++;
        if (pending_words.size() == 0) begin
          report_mismatch("word with none expected, kind", 64'(out_if.kind), '0);
        end else begin
          want = pending_words.pop_front();
          if (out_if.kind !== want.kind)
            report_mismatch("kind", 64'(out_if.kind), 64'(want.kind));
          if (out_if.key_offset !== want.key_offset)
            report_mismatch("key_offset", 64'(out_if.key_offset), 64'(want.key_offset));
          if (out_if.key_length !== want.key_length)
            report_mismatch("key_length", 64'(out_if.key_length), 64'(want.key_length));
          if (out_if.index_value !== want.index_value)
            report_mismatch("index_value", out_if.index_value, want.index_value);
          if (out_if.parse_failed !== want.parse_failed)
            report_mismatch("parse_failed", 64'(out_if.parse_failed),
                            64'(want.parse_failed));
          if (out_if.last_of_item !== want.last_of_item)
            report_mismatch("last_of_item", 64'(out_if.last_of_item),
                            64'(want.last_of_item));
        end
      end
      out_if.ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int unsigned mixed_end;
    in_if.valid     = 1'b0;
    in_if.char_byte = '0;
    in_if.is_last   = 1'b0;
    out_if.ready    = 1'b0;
    rst_n           = 1'b0;
    accepted_bytes  = 0;
    words_seen      = 0;
    mismatches      = 0;
    idle_phase      = 0;
    clear_path_state();

    // directed paths
    push_text("$");       commit_path(1'b0);   // root only
    push_text("$.a[*]");  commit_path(1'b0);   // key then wildcard
    push_text("[-12]");   commit_path(1'b1);   // negative index, after the result side empties
    push_text("[\"a\\");  commit_path(1'b0);   // unclosed quote, trailing backslash
    push_text("['b'x");   commit_path(1'b0);   // no bracket after the quote
    push_text("['\\''].k"); commit_path(1'b0); // escaped quote inside the key
    push_text("[x");      commit_path(1'b0);   // bad byte after bracket
    push_text("[-]");     commit_path(1'b0);   // bracket closed with no digit
    push_text("[*x");     commit_path(1'b0);   // wildcard not closed
    push_text("[5");      commit_path(1'b0);   // path ends inside a bracket
    path_buf.push_back(8'h00);
    path_buf.push_back(8'hFF);
    commit_path(1'b0);                         // extreme byte values in a key

    // random paths, now and then waiting for the result side to empty
    mixed_end = char_stream.size() + RANDOM_BYTES;
    while (char_stream.size() < mixed_end) begin
      build_random_path();
      commit_path($urandom_range(39) == 0);
    end
    mixed_end    = char_stream.size();
    phase_edge_a = mixed_end * 2 / 5;
    phase_edge_b = mixed_end * 4 / 5;

    // ten more random paths at the end, without drain markers
    repeat (10) begin
      build_random_path();
      commit_path(1'b0);
    end
    total_bytes = char_stream.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_bytes != total_bytes) @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    // let any stray word show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
